### src/optical_pulse_frame_receiver_macros.svh
// Assertion macros shared by the optical pulse frame receiver RTL.
`ifndef OPTICAL_PULSE_FRAME_RECEIVER_MACROS_SVH
`define OPTICAL_PULSE_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define OPFR_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define OPFR_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

### src/opfr_pkg.sv
// Types and constants of the optical pulse frame receiver.
`default_nettype none
package opfr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int RUN_BITS    = 16;
    localparam int LIGHT_W     = 16;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam int MS_W      = 7;
    localparam int RPER_W    = 10;
    localparam int RTOL_W    = 10;
    localparam int DPER_W    = 11;
    localparam int DTOL_W    = 10;
    localparam int PULSE_W   = 4;
    localparam int MS_RUN_W  = RUN_BITS + MS_W;
    localparam int TOTAL_W   = MS_RUN_W + 1;
    localparam int WIN_W     = DPER_W + 1;

    localparam logic [MS_W-1:0]    MS_PER_TICK_RST  = MS_W'(10);
    localparam logic [RPER_W-1:0]  RESET_PERIOD_RST = RPER_W'(100);
    localparam logic [RTOL_W-1:0]  RESET_TOL_RST    = RTOL_W'(40);
    localparam logic [DPER_W-1:0]  DATA_PERIOD_RST  = DPER_W'(200);
    localparam logic [DTOL_W-1:0]  DATA_TOL_RST     = DTOL_W'(50);
    localparam logic [PULSE_W-1:0] PULSES_RST       = PULSE_W'(5);

    localparam logic [SAMPLE_BITS-1:0] HIGH_LEVEL_RST = SAMPLE_BITS'(1000);

    localparam logic [2:0] REG_MS_PER_TICK   = 3'd0;
    localparam logic [2:0] REG_RESET_PERIOD  = 3'd1;
    localparam logic [2:0] REG_RESET_TOL     = 3'd2;
    localparam logic [2:0] REG_DATA_PERIOD   = 3'd3;
    localparam logic [2:0] REG_DATA_TOL      = 3'd4;
    localparam logic [2:0] REG_PULSES_NEEDED = 3'd5;

    localparam logic [7:0] FRAME_HEADER = 8'hFF;
    localparam logic [3:0] FRAME_LEN    = 4'd4;
    localparam logic [3:0] DROP_LEN     = 4'd8;
    localparam int         FRAME_BYTES  = 4;

    typedef enum logic [1:0] {
        TREND_NONE = 2'd0,
        TREND_RISE = 2'd1,
        TREND_FALL = 2'd2
    } t_trend;

    typedef struct packed {
        logic [MS_W-1:0]    ms_per_tick;
        logic [RPER_W-1:0]  reset_period_ms;
        logic [RTOL_W-1:0]  reset_tolerance_ms;
        logic [DPER_W-1:0]  data_period_ms;
        logic [DTOL_W-1:0]  data_tolerance_ms;
        logic [PULSE_W-1:0] reset_pulses_needed;
    } t_cfg;

    typedef struct packed {
        logic [LIGHT_W-1:0] light_sample;
        logic               clear_pending;
    } t_in_item;

    typedef struct packed {
        logic       frame_done;
        logic [7:0] seconds_bcd;
        logic [7:0] minutes_bcd;
        logic [7:0] hours_bcd;
        logic       light_is_on;
        logic       frame_waiting;
    } t_out_item;

    typedef struct packed {
        logic                rise;
        logic [RUN_BITS-1:0] on_ticks;
        logic [RUN_BITS-1:0] off_ticks;
    } t_period_evt;

    typedef struct packed {
        logic       done;
        logic       pending;
        logic [7:0] seconds;
        logic [7:0] minutes;
        logic [7:0] hours;
    } t_frame_status;

endpackage
`default_nettype wire

### src/opfr_level.sv
// Adaptive level tracking, slicing and run timing of the light samples.
`default_nettype none
module opfr_level (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire logic [opfr_pkg::SAMPLE_BITS-1:0] i_sample,
    output opfr_pkg::t_period_evt                 o_evt,
    output logic                                  o_light_on
);
    import opfr_pkg::*;

    localparam int W8  = SAMPLE_BITS + 3;
    localparam int W16 = SAMPLE_BITS + 4;
    localparam int WT  = SAMPLE_BITS + 2;
    localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

    logic [SAMPLE_BITS-1:0] r_low, n_low, r_high, n_high, r_prev, n_prev;
    t_trend                 r_trend, n_trend;
    logic                   r_on, n_on;
    logic [RUN_BITS-1:0]    r_run, n_run, r_on_ticks, n_on_ticks;

    logic [W8-1:0]          sum_high, sum_low;
    logic [W16-1:0]         sum_low2, sum_high2;
    logic [SAMPLE_BITS-1:0] high1, low1, high2, low2;
    logic [WT-1:0]          lhs, rhs;
    logic                   slice_on;
    logic [RUN_BITS-1:0]    run_base;

    always_comb begin
        sum_high = W8'(r_high) * W8'(7) + W8'(i_sample);
        sum_low  = W8'(r_low) * W8'(7) + W8'(i_sample);
        high1    = (i_sample > r_high) ? sum_high[W8-1:3] : r_high;
        low1     = (i_sample < r_low) ? sum_low[W8-1:3] : r_low;

        sum_low2  = W16'(low1) * W16'(15) + W16'(r_prev);
        sum_high2 = W16'(high1) * W16'(15) + W16'(r_prev);
        low2      = low1;
        high2     = high1;
        n_trend   = r_trend;
        if (i_sample > r_prev) begin
            if (r_trend == TREND_FALL) begin
                low2 = sum_low2[W16-1:4];
            end
            n_trend = TREND_RISE;
        end else if (i_sample < r_prev) begin
            if (r_trend == TREND_RISE) begin
                high2 = sum_high2[W16-1:4];
            end
            n_trend = TREND_FALL;
        end

        // on when sample >= floor((2*low + high) / 3)
        lhs      = WT'(low2) * WT'(2) + WT'(high2);
        rhs      = WT'(i_sample) * WT'(3) + WT'(3);
        slice_on = lhs < rhs;

        n_on_ticks = r_on_ticks;
        run_base   = r_run;
        if (slice_on && !r_on) begin
            run_base = '0;
        end else if (!slice_on && r_on) begin
            n_on_ticks = r_run;
            run_base   = '0;
        end

        n_low  = low2;
        n_high = high2;
        n_prev = i_sample;
        n_on   = slice_on;
        n_run  = (run_base != RUN_MAX) ? run_base + RUN_BITS'(1) : run_base;

        if (!i_en) begin
            n_low      = r_low;
            n_high     = r_high;
            n_prev     = r_prev;
            n_trend    = r_trend;
            n_on       = r_on;
            n_run      = r_run;
            n_on_ticks = r_on_ticks;
        end

        o_evt.rise      = slice_on && !r_on;
        o_evt.on_ticks  = r_on_ticks;
        o_evt.off_ticks = r_run;
        o_light_on      = n_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low      <= '0;
            r_high     <= HIGH_LEVEL_RST;
            r_prev     <= '0;
            r_trend    <= TREND_NONE;
            r_on       <= 1'b0;
            r_run      <= '0;
            r_on_ticks <= '0;
        end else begin
            r_low      <= n_low;
            r_high     <= n_high;
            r_prev     <= n_prev;
            r_trend    <= n_trend;
            r_on       <= n_on;
            r_run      <= n_run;
            r_on_ticks <= n_on_ticks;
        end
    end

endmodule
`default_nettype wire

### src/opfr_decoder.sv
// Period classification, reset pulse counting and frame assembly.
`default_nettype none
module opfr_decoder (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  opfr_pkg::t_cfg             i_cfg,
    input  wire logic                  i_process,
    input  wire logic                  i_clear,
    input  opfr_pkg::t_period_evt      i_evt,
    output logic                       o_live,
    output opfr_pkg::t_frame_status    o_status
);
    import opfr_pkg::*;

    function automatic logic in_window(input logic [TOTAL_W-1:0] v,
                                       input logic [WIN_W-1:0] nominal,
                                       input logic [WIN_W-1:0] tol);
        logic [WIN_W-1:0] lo;
        logic [WIN_W-1:0] hi;
        lo = (nominal > tol) ? nominal - tol : '0;
        hi = nominal + tol;
        return (v >= TOTAL_W'(lo)) && (v <= TOTAL_W'(hi));
    endfunction

    logic [3:0] r_rc, n_rc;
    logic       r_recv, n_recv;
    logic [2:0] r_bi, n_bi;
    logic [7:0] r_shift, n_shift;
    logic [3:0] r_bc, n_bc;
    logic [7:0] r_fb [FRAME_BYTES];
    logic [7:0] n_fb [FRAME_BYTES];
    logic       r_pend, n_pend;

    logic                pend_in;
    logic                period_ev;
    logic [MS_RUN_W-1:0] on_ms, off_ms;
    logic [TOTAL_W-1:0]  total;
    logic                in_reset, in_data, bit_val, done;
    logic [3:0]          rc1, bc1;
    logic [7:0]          new_shift, fb0;

    always_comb begin
        pend_in   = r_pend && !i_clear;
        o_live    = i_process && !pend_in;
        period_ev = o_live && i_evt.rise;

        on_ms    = MS_RUN_W'(i_evt.on_ticks) * MS_RUN_W'(i_cfg.ms_per_tick);
        off_ms   = MS_RUN_W'(i_evt.off_ticks) * MS_RUN_W'(i_cfg.ms_per_tick);
        total    = TOTAL_W'(on_ms) + TOTAL_W'(off_ms);
        in_reset = in_window(total, WIN_W'(i_cfg.reset_period_ms),
                             WIN_W'(i_cfg.reset_tolerance_ms));
        in_data  = in_window(total, WIN_W'(i_cfg.data_period_ms),
                             WIN_W'(i_cfg.data_tolerance_ms));
        bit_val  = TOTAL_W'(on_ms) > (total >> 1);

        rc1       = r_rc + 4'd1;
        bc1       = r_bc + 4'd1;
        new_shift = r_shift | (bit_val ? (8'd1 << r_bi) : 8'd0);
        fb0       = (r_bc == 4'd0) ? new_shift : r_fb[0];

        n_rc    = r_rc;
        n_recv  = r_recv;
        n_bi    = r_bi;
        n_shift = r_shift;
        n_bc    = r_bc;
        n_fb    = r_fb;
        n_pend  = i_process ? pend_in : r_pend;
        done    = 1'b0;

        if (period_ev) begin
            if (in_reset) begin
                if (rc1 == i_cfg.reset_pulses_needed) begin
                    n_rc    = '0;
                    n_recv  = 1'b1;
                    n_bi    = '0;
                    n_shift = '0;
                    n_bc    = '0;
                end else begin
                    n_rc = rc1;
                end
            end else if (!r_recv) begin
                n_rc = '0;
            end else if (!in_data) begin
                n_recv = 1'b0;
            end else begin
                n_bi    = r_bi + 3'd1;
                n_shift = new_shift;
                if (r_bi == 3'd7) begin
                    if (r_bc < FRAME_LEN) begin
                        n_fb[r_bc[1:0]] = new_shift;
                    end
                    n_bc    = bc1;
                    n_shift = '0;
                    if (fb0 == FRAME_HEADER && bc1 == FRAME_LEN) begin
                        n_pend = 1'b1;
                        n_recv = 1'b0;
                        done   = 1'b1;
                    end else if (bc1 >= DROP_LEN) begin
                        n_bc   = '0;
                        n_recv = 1'b0;
                    end
                end
            end
        end

        o_status.done    = done;
        o_status.pending = n_pend;
        o_status.seconds = n_fb[1];
        o_status.minutes = n_fb[2];
        o_status.hours   = n_fb[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc    <= '0;
            r_recv  <= 1'b0;
            r_bi    <= '0;
            r_shift <= '0;
            r_bc    <= '0;
            r_pend  <= 1'b0;
            for (int i = 0; i < FRAME_BYTES; i++) begin
                r_fb[i] <= '0;
            end
        end else begin
            r_rc    <= n_rc;
            r_recv  <= n_recv;
            r_bi    <= n_bi;
            r_shift <= n_shift;
            r_bc    <= n_bc;
            r_pend  <= n_pend;
            r_fb    <= n_fb;
        end
    end

endmodule
`default_nettype wire

### src/optical_pulse_frame_receiver.sv
// Top level of the optical pulse frame receiver: handshakes, registers, assembly.
// An accepted item is held in the input register, then loaded into the result
// register once the output can advance.
// Throughput: one item per cycle while the output is not stalled; the path runs through the input and result registers.
// Reset: synchronous, active low; clears levels, timers, frame state and config.
`default_nettype none
`include "optical_pulse_frame_receiver_macros.svh"
module optical_pulse_frame_receiver (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  opfr_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output opfr_pkg::t_out_item              o_out_item,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [opfr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [opfr_pkg::DATA_W-1:0] pwdata,
    output logic      [opfr_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import opfr_pkg::*;

    t_cfg          r_cfg;
    logic          r_in_valid;
    t_in_item      r_in;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          advance, process, accept, live, light_on;
    t_period_evt   evt;
    t_frame_status status;
    logic [2:0]    reg_idx;

    assign pready     = 1'b1;
    assign reg_idx    = paddr[4:2];
    assign advance    = !r_out_valid || !i_out_stall;
    assign process    = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ms_per_tick         <= MS_PER_TICK_RST;
            r_cfg.reset_period_ms     <= RESET_PERIOD_RST;
            r_cfg.reset_tolerance_ms  <= RESET_TOL_RST;
            r_cfg.data_period_ms      <= DATA_PERIOD_RST;
            r_cfg.data_tolerance_ms   <= DATA_TOL_RST;
            r_cfg.reset_pulses_needed <= PULSES_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_MS_PER_TICK:   r_cfg.ms_per_tick         <= pwdata[MS_W-1:0];
                REG_RESET_PERIOD:  r_cfg.reset_period_ms     <= pwdata[RPER_W-1:0];
                REG_RESET_TOL:     r_cfg.reset_tolerance_ms  <= pwdata[RTOL_W-1:0];
                REG_DATA_PERIOD:   r_cfg.data_period_ms      <= pwdata[DPER_W-1:0];
                REG_DATA_TOL:      r_cfg.data_tolerance_ms   <= pwdata[DTOL_W-1:0];
                REG_PULSES_NEEDED: r_cfg.reset_pulses_needed <= pwdata[PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MS_PER_TICK:   prdata = DATA_W'(r_cfg.ms_per_tick);
            REG_RESET_PERIOD:  prdata = DATA_W'(r_cfg.reset_period_ms);
            REG_RESET_TOL:     prdata = DATA_W'(r_cfg.reset_tolerance_ms);
            REG_DATA_PERIOD:   prdata = DATA_W'(r_cfg.data_period_ms);
            REG_DATA_TOL:      prdata = DATA_W'(r_cfg.data_tolerance_ms);
            REG_PULSES_NEEDED: prdata = DATA_W'(r_cfg.reset_pulses_needed);
            default:           prdata = '0;
        endcase
    end

    opfr_level u_level (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (live),
        .i_sample   (SAMPLE_BITS'(r_in.light_sample)),
        .o_evt      (evt),
        .o_light_on (light_on)
    );

    opfr_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_process (process),
        .i_clear   (r_in.clear_pending),
        .i_evt     (evt),
        .o_live    (live),
        .o_status  (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out.frame_done    <= status.done;
            r_out.seconds_bcd   <= status.seconds;
            r_out.minutes_bcd   <= status.minutes;
            r_out.hours_bcd     <= status.hours;
            r_out.light_is_on   <= light_on;
            r_out.frame_waiting <= status.pending;
        end
    end

    `OPFR_ASSERT_NOW(a_done_sets_waiting, i_clk, i_rst_n, r_out_valid && r_out.frame_done, r_out.frame_waiting, "frame_done without frame_waiting")
    `OPFR_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid && i_out_stall, "input stalled while a stage is free")
    `OPFR_ASSERT_NEXT(a_process_fills_out, i_clk, i_rst_n, process, r_out_valid, "processed item did not reach the result register")

endmodule
`default_nettype wire

### tb/tb_optical_pulse_frame_receiver.sv
// Self-checking testbench for the optical pulse frame receiver: pulse-train stimulus vs. predictor.
`timescale 1ns / 1ps
module tb_optical_pulse_frame_receiver;
    import opfr_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int NUM_PHASES     = 5;
    localparam int PHASE_ITEMS    = 80;
    localparam int BREAKER_CAP    = 300;
    localparam int SPAN_CAP       = 10;

    typedef enum logic [1:0] {
        STALL_OFF,
        STALL_LIGHT,
        STALL_PATTERN,
        STALL_HEAVY
    } t_stall_mode;

    logic                i_clk;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    t_in_item            in_item   = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                out_stall = 1'b0;
    t_out_item           o_out_item;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    optical_pulse_frame_receiver DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    t_cfg phase_cfg [NUM_PHASES] = '{
        '{7'd100, 10'd150,  10'd50,   11'd300,  10'd50,   4'd1},
        '{7'd50,  10'd100,  10'd0,    11'd200,  10'd0,    4'd3},
        '{7'd1,   10'd0,    10'd0,    11'd0,    10'd0,    4'd0},
        '{7'd100, 10'd50,   10'd1000, 11'd400,  10'd100,  4'd0},
        '{7'd127, 10'd254,  10'd0,    11'd508,  10'd127,  4'd2}
    };

    t_cfg cfg_model = '{MS_PER_TICK_RST, RESET_PERIOD_RST, RESET_TOL_RST,
                        DATA_PERIOD_RST, DATA_TOL_RST, PULSES_RST};

    logic [SAMPLE_BITS-1:0] lvl_low     = '0;
    logic [SAMPLE_BITS-1:0] lvl_high    = HIGH_LEVEL_RST;
    logic [SAMPLE_BITS-1:0] prev_sample = '0;
    t_trend                 trend       = TREND_NONE;
    logic                   is_on       = 1'b0;
    logic [RUN_BITS-1:0]    run_cnt     = '0;
    logic [RUN_BITS-1:0]    on_cnt      = '0;
    logic [3:0]             pulse_cnt   = '0;
    logic                   rx_active   = 1'b0;
    logic [2:0]             bit_pos     = '0;
    logic [7:0]             byte_acc    = '0;
    logic [3:0]             byte_cnt    = '0;
    logic [7:0]             rx_bytes [FRAME_BYTES] = '{default: 8'h00};
    logic                   held        = 1'b0;

    t_in_item    light_q [$];
    t_out_item   status_q [$];
    t_out_item   predicted;
    t_out_item   expected;
    int          items_total  = 0;
    int          accepted_cnt = 0;
    int          errors       = 0;
    int          idle_cycles  = 0;
    int          gap_left     = 0;
    int          burst_left   = 0;
    int          mode_left    = 0;
    logic [2:0]  stall_tick   = '0;
    t_stall_mode stall_mode   = STALL_OFF;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit in_win(int unsigned v, int unsigned nom, int unsigned tol);
        int unsigned lo;
        lo = (nom > tol) ? nom - tol : 0;
        return (v >= lo) && (v <= nom + tol);
    endfunction

    function automatic bit close_period(int unsigned on_ms, int unsigned off_ms);
        int unsigned total;
        total = on_ms + off_ms;
        if (in_win(total, cfg_model.reset_period_ms, cfg_model.reset_tolerance_ms)) begin
            pulse_cnt = pulse_cnt + 4'd1;
            if (pulse_cnt == cfg_model.reset_pulses_needed) begin
                pulse_cnt = '0;
                rx_active = 1'b1;
                bit_pos   = '0;
                byte_acc  = '0;
                byte_cnt  = '0;
            end
            return 1'b0;
        end
        if (!rx_active) begin
            pulse_cnt = '0;
            return 1'b0;
        end
        if (!in_win(total, cfg_model.data_period_ms, cfg_model.data_tolerance_ms)) begin
            rx_active = 1'b0;
            return 1'b0;
        end
        if (on_ms > total / 2)
            byte_acc[bit_pos] = 1'b1;
        bit_pos = bit_pos + 3'd1;
        if (bit_pos != 3'd0)
            return 1'b0;
        if (byte_cnt < FRAME_LEN)
            rx_bytes[byte_cnt[1:0]] = byte_acc;
        byte_cnt = byte_cnt + 4'd1;
        byte_acc = '0;
        if (rx_bytes[0] == FRAME_HEADER && byte_cnt == FRAME_LEN) begin
            held      = 1'b1;
            rx_active = 1'b0;
            return 1'b1;
        end
        if (byte_cnt >= DROP_LEN) begin
            byte_cnt  = '0;
            rx_active = 1'b0;
        end
        return 1'b0;
    endfunction

    task automatic receiver_step(input t_in_item it, output t_out_item r);
        int unsigned s;
        int unsigned thr;
        logic        done;
        done = 1'b0;
        if (it.clear_pending)
            held = 1'b0;
        if (!held) begin
            s = it.light_sample;
            if (s > lvl_high)
                lvl_high = SAMPLE_BITS'((32'(lvl_high) * 32'd7 + s) / 32'd8);
            if (s < lvl_low)
                lvl_low = SAMPLE_BITS'((32'(lvl_low) * 32'd7 + s) / 32'd8);
            if (s > prev_sample) begin
                if (trend == TREND_FALL)
                    lvl_low = SAMPLE_BITS'((32'(lvl_low) * 32'd15 + 32'(prev_sample)) / 32'd16);
                trend = TREND_RISE;
            end else if (s < prev_sample) begin
                if (trend == TREND_RISE)
                    lvl_high = SAMPLE_BITS'((32'(lvl_high) * 32'd15 + 32'(prev_sample)) / 32'd16);
                trend = TREND_FALL;
            end
            thr = (32'(lvl_low) * 32'd2 + 32'(lvl_high)) / 32'd3;
            if (s >= thr) begin
                if (!is_on) begin
                    done    = close_period(32'(on_cnt) * 32'(cfg_model.ms_per_tick),
                                           32'(run_cnt) * 32'(cfg_model.ms_per_tick));
                    is_on   = 1'b1;
                    run_cnt = '0;
                end
            end else if (is_on) begin
                is_on   = 1'b0;
                on_cnt  = run_cnt;
                run_cnt = '0;
            end
            if (run_cnt != '1)
                run_cnt = run_cnt + 1'b1;
            prev_sample = s[SAMPLE_BITS-1:0];
        end
        r.frame_done    = done;
        r.seconds_bcd   = rx_bytes[1];
        r.minutes_bcd   = rx_bytes[2];
        r.hours_bcd     = rx_bytes[3];
        r.light_is_on   = is_on;
        r.frame_waiting = held;
    endtask

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (light_q.size() > 0) begin
                in_valid <= 1'b1;
                in_item  <= light_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 3'd1;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(3, 0));
                mode_left  <= $urandom_range(300, 32);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_OFF:     out_stall <= 1'b0;
                STALL_LIGHT:   out_stall <= ($urandom_range(9, 0) < 3);
                STALL_PATTERN: out_stall <= (stall_tick < 3'd3);
                default:       out_stall <= ($urandom_range(9, 0) < 7);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                receiver_step(in_item, predicted);
                status_q.push_back(predicted);
                accepted_cnt++;
            end
            if (o_out_valid && !out_stall) begin
                if (status_q.size() == 0) begin
                    $error("result item with no expected status pending");
                    errors++;
                end else begin
                    expected = status_q.pop_front();
                    check_field("frame_done", expected.frame_done, o_out_item.frame_done);
                    check_field("seconds_bcd", expected.seconds_bcd, o_out_item.seconds_bcd);
                    check_field("minutes_bcd", expected.minutes_bcd, o_out_item.minutes_bcd);
                    check_field("hours_bcd", expected.hours_bcd, o_out_item.hours_bcd);
                    check_field("light_is_on", expected.light_is_on, o_out_item.light_is_on);
                    check_field("frame_waiting", expected.frame_waiting,
                                o_out_item.frame_waiting);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [DATA_W-1:0] reg_value(t_cfg c, logic [2:0] idx);
        case (idx)
            REG_MS_PER_TICK:   return DATA_W'(c.ms_per_tick);
            REG_RESET_PERIOD:  return DATA_W'(c.reset_period_ms);
            REG_RESET_TOL:     return DATA_W'(c.reset_tolerance_ms);
            REG_DATA_PERIOD:   return DATA_W'(c.data_period_ms);
            REG_DATA_TOL:      return DATA_W'(c.data_tolerance_ms);
            default:           return DATA_W'(c.reset_pulses_needed);
        endcase
    endfunction

    task automatic apb_access(logic wr, logic [2:0] idx, logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(t_cfg c);
        logic [DATA_W-1:0] rd;
        for (int i = REG_MS_PER_TICK; i <= REG_PULSES_NEEDED; i++)
            apb_access(1'b1, 3'(i), reg_value(c, 3'(i)), rd);
        cfg_model = c;
        for (int i = REG_MS_PER_TICK; i <= REG_PULSES_NEEDED; i++) begin
            apb_access(1'b0, 3'(i), '0, rd);
            if (rd !== reg_value(c, 3'(i))) begin
                $error("prdata reg %0d: expected %0h, actual %0h", i, reg_value(c, 3'(i)), rd);
                errors++;
            end
        end
    endtask

    task automatic push_sample(logic [LIGHT_W-1:0] v, logic clr);
        light_q.push_back(t_in_item'{light_sample: v, clear_pending: clr});
        items_total++;
    endtask

    task automatic send_run(bit lit, int n, logic clr);
        repeat (n)
            push_sample(lit ? LIGHT_W'($urandom_range(65535, 30000))
                            : LIGHT_W'($urandom_range(63, 0)), clr);
    endtask

    task automatic send_pulse(int on_t, int off_t);
        send_run(1'b1, on_t, 1'b0);
        send_run(1'b0, off_t, 1'b0);
    endtask

    function automatic int pick_ticks(int unsigned nom, int unsigned tol, int min_t,
                                      bit avoid_reset);
        int unsigned m;
        int unsigned lo_ms;
        int          lo_t;
        int          hi_t;
        int          t;
        m     = (cfg_model.ms_per_tick == 0) ? 1 : cfg_model.ms_per_tick;
        lo_ms = (nom > tol) ? nom - tol : 0;
        lo_t  = (lo_ms + m - 1) / m;
        if (lo_t < min_t)
            lo_t = min_t;
        hi_t = (nom + tol) / m;
        if (hi_t > lo_t + SPAN_CAP)
            hi_t = lo_t + SPAN_CAP;
        if (hi_t < lo_t)
            return lo_t;
        t = lo_t;
        repeat (16) begin
            t = $urandom_range(hi_t, lo_t);
            if (!avoid_reset || !in_win(t * m, cfg_model.reset_period_ms,
                                        cfg_model.reset_tolerance_ms))
                return t;
        end
        return t;
    endfunction

    task automatic send_breaker();
        int unsigned m;
        int          big;
        m   = (cfg_model.ms_per_tick == 0) ? 1 : cfg_model.ms_per_tick;
        big = cfg_model.reset_period_ms + cfg_model.reset_tolerance_ms;
        if (cfg_model.data_period_ms + cfg_model.data_tolerance_ms > big)
            big = cfg_model.data_period_ms + cfg_model.data_tolerance_ms;
        big = big / m + 2;
        if (big > BREAKER_CAP)
            big = BREAKER_CAP;
        send_pulse(1, big - 1);
    endtask

    task automatic send_bit(bit v, int t);
        int on_t;
        on_t = v ? $urandom_range(t - 1, t / 2 + 1) : $urandom_range(t / 2, 1);
        send_pulse(on_t, t - on_t);
    endtask

    task automatic send_frame(bit hdr, bit broken);
        int         needed;
        int         nbytes;
        int         cut;
        int         bitno;
        int         t;
        int         on_t;
        logic [7:0] b;
        needed = (cfg_model.reset_pulses_needed == 0) ? 16 : cfg_model.reset_pulses_needed;
        nbytes = hdr ? FRAME_LEN : DROP_LEN;
        cut    = broken ? $urandom_range(nbytes * 8 - 1, 0) : -1;
        bitno  = 0;
        send_breaker();
        send_breaker();
        repeat (needed) begin
            t    = pick_ticks(cfg_model.reset_period_ms, cfg_model.reset_tolerance_ms, 2, 1'b0);
            on_t = $urandom_range(t - 1, 1);
            send_pulse(on_t, t - on_t);
        end
        for (int k = 0; k < nbytes; k++) begin
            if (k == 0)
                b = hdr ? FRAME_HEADER : 8'($urandom_range(254, 0));
            else
                b = 8'($urandom_range(255, 0));
            for (int j = 0; j < 8; j++) begin
                if (bitno == cut) begin
                    send_breaker();
                    return;
                end
                t = pick_ticks(cfg_model.data_period_ms, cfg_model.data_tolerance_ms, 3, 1'b1);
                send_bit(b[j], t);
                bitno++;
            end
        end
        send_run(1'b1, $urandom_range(3, 1), 1'b0);
        send_run(1'b0, $urandom_range(4, 0), 1'b0);
        send_run(1'b0, 1, 1'b1);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(24, 1))
            push_sample(LIGHT_W'($urandom_range(65535, 0)), ($urandom_range(3, 0) == 0));
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (accepted_cnt != items_total || status_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int sel;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hAAAA, 1'b1);
        push_sample(16'h5555, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h0001, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h0000, 1'b1);
        push_sample(16'h0000, 1'b0);
        wait_idle();
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_config(phase_cfg[p]);
            while (items_total < (p + 1) * PHASE_ITEMS) begin
                sel = $urandom_range(9, 0);
                if (sel < 6)
                    send_frame($urandom_range(3, 0) != 0, 1'b0);
                else if (sel < 8)
                    send_frame($urandom_range(1, 0), 1'b1);
                else
                    send_noise();
            end
            wait_idle();
        end
        repeat (8) @(posedge i_clk);
        if (errors == 0 && status_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
